// ===== rtl/pcm_volume_scaler_with_dither_defines.svh =====
// ----------------------------------------------------------------------------
// PCM volume scaler with dither: assertion macros
// Concurrent check macros shared by the RTL; empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef PCM_VOLUME_SCALER_WITH_DITHER_DEFINES_SVH
`define PCM_VOLUME_SCALER_WITH_DITHER_DEFINES_SVH

`ifndef SYNTHESIS
// Check sampled on clk, disabled while rst_n is low
`define PVSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pvsd check failed");
// Check sampled on clk that also holds through reset
`define PVSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("pvsd check failed");
`else
`define PVSD_ASSERT(label, prop)
`define PVSD_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/pvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvsd_pkg
// Transaction types, request codes and gain constants for the volume scaler.
// ----------------------------------------------------------------------------
package pvsd_pkg;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // Q15 gain thresholds
  localparam logic [15:0] GAIN_UNITY      = 16'd32768;
  localparam logic [15:0] GAIN_DITHER_MAX = 16'd16384;
  localparam int unsigned FRAC_BITS       = 15;

  // Widest ring address over the supported depth range
  localparam int unsigned RING_AW_MAX = 16;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample_in;
    logic               end_of_buffer;
    logic [10:0]        noise_index;
    logic signed [15:0] noise_value;
  } pvsd_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               end_of_buffer_out;
  } pvsd_out_t;

  // Noise ring write port
  typedef struct packed {
    logic                   en;
    logic [RING_AW_MAX-1:0] addr;
    logic [15:0]            data;
  } pvsd_ring_wr_t;

endpackage

// ===== rtl/pvsd_noise_ring.sv =====
// ----------------------------------------------------------------------------
// pvsd_noise_ring
// Dither noise ring: one write port, one read port with registered output.
// ----------------------------------------------------------------------------
module pvsd_noise_ring #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                          clk,
  input  pvsd_pkg::pvsd_ring_wr_t       wr,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [15:0]                   rd_data
);
  import pvsd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  // Write and registered read; the read data holds when not enabled
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pcm_volume_scaler_with_dither.sv =====
// ----------------------------------------------------------------------------
// pcm_volume_scaler_with_dither
// Q15 volume control for 16-bit PCM with dither from a loadable noise ring.
// ----------------------------------------------------------------------------
// One transaction per clock in steady state while out_stall is low. An
// accepted sample passes through the stage 1, stage 2 and output registers
// and is then offered as a result. Load transactions write one noise ring
// entry and return nothing. The ring read and the first stage registers
// load at the accepting edge, the 16x17 multiply lies between the first and
// second stage, and the dither add and Q15 truncation lie between the second
// stage and the output register. A gain of 32768 or more passes samples
// through unchanged; at 16384 or less each sample takes one ring entry and
// the read pointer steps down, wrapping from zero to NOISE_DEPTH-1. No
// clearing pass: ring entries must be loaded before they are used.
// ----------------------------------------------------------------------------
`include "pcm_volume_scaler_with_dither_defines.svh"

module pcm_volume_scaler_with_dither #(
  parameter int unsigned NOISE_DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  // input transactions
  input  logic                in_valid,
  output logic                in_stall,
  input  pvsd_pkg::pvsd_in_t  in_data,
  // result transactions
  output logic                out_valid,
  input  logic                out_stall,
  output pvsd_pkg::pvsd_out_t out_data,
  // gain register
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import pvsd_pkg::*;

  localparam int unsigned AW = $clog2(NOISE_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(NOISE_DEPTH - 1);
  localparam logic [16:0] DEPTH_W = 17'(NOISE_DEPTH);

  // Gain register
  logic [15:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_UNITY;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // Stage valids and flow control
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_ready, s2_ready, s1_ready;
  logic in_acc, is_sample, is_load, use_dither, idx_ok;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && s1_ready;

  assign is_sample  = in_acc && (in_data.req_type == REQ_SAMPLE);
  assign is_load    = in_acc && (in_data.req_type == REQ_LOAD);
  assign use_dither = gain_r <= GAIN_DITHER_MAX;
  assign idx_ok     = {6'd0, in_data.noise_index} < DEPTH_W;

  // Read pointer: steps down on each dithered sample
  logic [AW-1:0] ptr_r, ptr_nxt;

  assign ptr_nxt = (ptr_r == '0) ? PTR_LAST : ptr_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= PTR_LAST;
    end else if (is_sample && use_dither) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Noise ring
  pvsd_ring_wr_t ring_wr;
  logic [15:0]   ring_rd_data;

  assign ring_wr.en   = is_load && idx_ok;
  assign ring_wr.addr = {5'd0, in_data.noise_index};
  assign ring_wr.data = in_data.noise_value;

  pvsd_noise_ring #(
    .DEPTH (NOISE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (is_sample && use_dither),
    .rd_addr (ptr_r),
    .rd_data (ring_rd_data)
  );

  // Stage 1: sample, gain operand, dither flag; ring data arrives here
  logic signed [15:0] s1_sample_r;
  logic [15:0]        s1_gain_r;
  logic               s1_dith_r, s1_eob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      s1_sample_r <= in_data.sample_in;
      s1_gain_r   <= (gain_r >= GAIN_UNITY) ? GAIN_UNITY : gain_r;
      s1_dith_r   <= use_dither;
      s1_eob_r    <= in_data.end_of_buffer;
    end
  end

  // Stage 2: product and selected noise (passthrough uses a unity operand)
  logic signed [32:0] s1_prod;
  logic signed [31:0] s2_prod_r;
  logic signed [15:0] s2_noise_r;
  logic               s2_eob_r;

  assign s1_prod = s1_sample_r * $signed({1'b0, s1_gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_prod_r  <= s1_prod[31:0];
      s2_noise_r <= s1_dith_r ? $signed(ring_rd_data) : 16'sd0;
      s2_eob_r   <= s1_eob_r;
    end
  end

  // Stage 3: dither add, divide by 2^15 truncating toward zero
  logic signed [32:0] s2_sum, s2_bias, s2_quot;

  assign s2_sum  = 33'(s2_prod_r) + 33'(s2_noise_r);
  assign s2_bias = s2_sum[32] ? 33'sd32767 : 33'sd0;
  assign s2_quot = (s2_sum + s2_bias) >>> FRAC_BITS;

  pvsd_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_v_r) begin
      out_data_r.sample_out        <= s2_quot[15:0];
      out_data_r.end_of_buffer_out <= s2_eob_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // Checks
  `PVSD_ASSERT(a_ptr_hold, !(is_sample && use_dither) |=> $stable(ptr_r))
  `PVSD_ASSERT(a_ptr_wrap, (is_sample && use_dither && ptr_r == '0) |=> (ptr_r == PTR_LAST))
  `PVSD_ASSERT(a_stall_full, in_stall |-> (s1_v_r && s2_v_r && out_v_r))
  `PVSD_ASSERT(a_dither_gain, (s1_v_r && s1_dith_r) |-> (s1_gain_r <= GAIN_DITHER_MAX))
  `PVSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_v_r && !s2_v_r && !out_v_r))

endmodule

// ===== tb/pcm_volume_scaler_with_dither_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_volume_scaler_with_dither_test
// Self-checking bench for the Q15 volume scaler with noise ring dither.
// A bit-accurate scaler model predicts every accepted sample transaction;
// results are checked in order against it. Directed cases cover the gain
// and sample extremes and the dither corner cases, then random traffic runs
// under several idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module pcm_volume_scaler_with_dither_test;
  import pvsd_pkg::*;

  localparam int RING_DEPTH = 2048;

  // DUT signals
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pvsd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pvsd_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Scaler model state
  logic [15:0]        gain_q15;
  logic signed [15:0] noise_ring [RING_DEPTH];
  bit                 ring_loaded [RING_DEPTH];
  logic [10:0]        dither_ptr;

  // Scaled samples waiting for the DUT
  pvsd_out_t pending_results[$];
  int        mismatch_count = 0;

  // Traffic shaping
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  pcm_volume_scaler_with_dither u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("pcm_volume_scaler_with_dither: mismatch");
    $finish;
  end

  // Result side: random stall, or a counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    pvsd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: sample_out %0d", out_data.sample_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_data.sample_out);
          mismatch_count++;
        end
        if (out_data.end_of_buffer_out !== want.end_of_buffer_out) begin
          $error("end_of_buffer_out: expected %0b, got %0b",
                 want.end_of_buffer_out, out_data.end_of_buffer_out);
          mismatch_count++;
        end
      end
    end
  end

  // Model: apply one accepted transaction, queue the scaled sample if any
  function automatic void predict_scaled_sample(pvsd_in_t t);
    int        acc;
    pvsd_out_t res;
    if (t.req_type == REQ_LOAD) begin
      noise_ring[t.noise_index] = t.noise_value;
      ring_loaded[t.noise_index] = 1'b1;
    end else begin
      if (gain_q15 >= GAIN_UNITY) begin
        acc = int'(t.sample_in);
      end else begin
        acc = int'(t.sample_in) * int'(gain_q15);
        // dither: take the ring entry under the pointer, then step down
        if (gain_q15 <= GAIN_DITHER_MAX) begin
          acc = acc + int'(noise_ring[dither_ptr]);
          dither_ptr = dither_ptr - 11'd1;
        end
        acc = acc / int'(GAIN_UNITY);
      end
      res.sample_out = acc[15:0];
      res.end_of_buffer_out = t.end_of_buffer;
      pending_results.push_back(res);
    end
  endfunction

  function automatic pvsd_in_t load_item(logic [10:0] idx, logic [15:0] val);
    pvsd_in_t t;
    t.req_type = REQ_LOAD;
    t.sample_in = 16'($urandom);
    t.end_of_buffer = 1'($urandom);
    t.noise_index = idx;
    t.noise_value = val;
    return t;
  endfunction

  function automatic pvsd_in_t sample_item(logic [15:0] s, logic eob);
    pvsd_in_t t;
    t.req_type = REQ_SAMPLE;
    t.sample_in = s;
    t.end_of_buffer = eob;
    t.noise_index = 11'($urandom);
    t.noise_value = 16'($urandom);
    return t;
  endfunction

  function automatic logic [15:0] rand_pcm();
    if ($urandom_range(9) != 0) return 16'($urandom);
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(GAIN_DITHER_MAX));
      4, 5: return 16'($urandom_range(GAIN_UNITY - 1, GAIN_DITHER_MAX + 1));
      6: return 16'($urandom_range(65535, GAIN_UNITY));
      default: begin
        case ($urandom_range(6))
          0: return 16'd0;
          1: return 16'd1;
          2: return GAIN_DITHER_MAX;
          3: return GAIN_DITHER_MAX + 16'd1;
          4: return GAIN_UNITY - 16'd1;
          5: return GAIN_UNITY;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  // Offer one transaction, with random idle cycles in front
  task automatic send_transaction(pvsd_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_scaled_sample(t);
  endtask

  // Sample transaction; loads the ring entry first if dither would read it unset
  task automatic send_sample(logic [15:0] s, logic eob);
    if (gain_q15 <= GAIN_DITHER_MAX && !ring_loaded[dither_ptr])
      send_transaction(load_item(dither_ptr, 16'($urandom)));
    send_transaction(sample_item(s, eob));
  endtask

  // Stop offering and wait until every result is back and the pipe is empty
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] val);
    drain_pipeline();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    gain_q15 = val;
  endtask

  // Reset gain is unity: samples pass through untouched
  task automatic test_passthrough_at_reset();
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h0001, 1'b0);
  endtask

  // Largest gain word, largest scaling gain and first gain without dither
  task automatic test_gain_extremes();
    write_gain(16'hffff);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    write_gain(GAIN_UNITY - 16'd1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'hffff, 1'b0);
    write_gain(GAIN_DITHER_MAX + 16'd1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
  endtask

  // Dither corners: noise extremes incl. -32768, gains 16384, 1 and 0
  task automatic test_dither_extremes();
    logic [10:0] p;
    write_gain(GAIN_DITHER_MAX);
    p = dither_ptr;
    send_transaction(load_item(p, 16'h8000));
    send_transaction(load_item(p - 11'd1, 16'h7fff));
    send_transaction(load_item(p - 11'd2, 16'h8001));
    send_transaction(load_item(p - 11'd3, 16'h0000));
    send_transaction(load_item(11'd0, 16'h7fff));
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    write_gain(16'd0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);
    write_gain(16'd1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
  endtask

  // Mixed samples and ring loads, gain changed every so often
  task automatic test_random_traffic(int n, int idle_pct, int stall_p);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int i = 0; i < n; i++) begin
      if (i % 110 == 0) write_gain(pick_gain());
      if ($urandom_range(4) != 0)
        send_sample(rand_pcm(), 1'($urandom));
      else
        send_transaction(load_item(11'($urandom), 16'($urandom)));
    end
  endtask

  // Long output hold-off while the input keeps offering
  task automatic test_input_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_gain(16'($urandom_range(GAIN_DITHER_MAX)));
    hold_left = 300;
    for (int i = 0; i < 60; i++) send_sample(rand_pcm(), 1'($urandom));
  endtask

  initial begin
    gain_q15 = GAIN_UNITY;
    dither_ptr = 11'(RING_DEPTH - 1);
    for (int i = 0; i < RING_DEPTH; i++) begin
      noise_ring[i] = '0;
      ring_loaded[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough_at_reset();
    test_gain_extremes();
    test_dither_extremes();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 76, 0);
    test_random_traffic(300, 0, 76);
    test_random_traffic(300, 35, 35);
    test_input_backpressure();

    drain_pipeline();
    if (mismatch_count == 0)
      $display("pcm_volume_scaler_with_dither: match");
    else
      $display("pcm_volume_scaler_with_dither: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pvsd_pkg.sv
rtl/pvsd_noise_ring.sv
rtl/pcm_volume_scaler_with_dither.sv
tb/pcm_volume_scaler_with_dither_test.sv
